[rtl/gode_pkg.sv]
// ----------------------------------------------------------------------------
// gode_pkg
// Shared types, sizes and constants of the grid obstacle distance engine.
// ----------------------------------------------------------------------------
package gode_pkg;

	localparam int MAX_DIM   = 63;
	localparam int COORD_W   = $clog2(MAX_DIM + 1);
	localparam int ADDR_W    = 2 * COORD_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int EXT_W     = ((COORD_W > 7) ? COORD_W : 7) + 2;
	localparam int D2_W      = 2 * COORD_W + 1;
	localparam int FRAC_W    = 8;
	localparam int RAD_W     = ((D2_W + 2 * FRAC_W + 1) / 2) * 2;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int SAT_W     = (ROOT_W > 16) ? ROOT_W : 16;
	localparam int CFG_W     = 6;
	localparam int DIST_W    = 15;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [CFG_W-1:0]  CFG_RESET = 6'd63;

	localparam logic OP_FILL  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_WIDTH_MAX  = 1'b0;
	localparam logic REG_HEIGHT_MAX = 1'b1;

	typedef struct packed {
		logic              operation;
		logic signed [7:0] corner_one_x;
		logic signed [7:0] corner_one_y;
		logic signed [7:0] corner_two_x;
		logic signed [7:0] corner_two_y;
		logic              fill_value;
	} gode_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              cell_occupied;
		logic              no_obstacle;
	} gode_result_t;

	typedef struct packed {
		logic load;
		logic step;
		logic write;
		logic scan;
		logic sq_start;
		logic emit;
	} gode_cmd_t;

	typedef struct packed {
		logic is_query;
		logic fill_empty;
		logic last;
		logic sq_done;
	} gode_status_t;

endpackage

[rtl/gode_isqrt.sv]
// ----------------------------------------------------------------------------
// gode_isqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module gode_isqrt import gode_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [REM_W-1:0]  shifted;
	logic [REM_W-1:0]  trial;
	logic              take;

	assign shifted = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign take    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= shifted - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("root done without a running iteration");

endmodule

[rtl/gode_datapath.sv]
// ----------------------------------------------------------------------------
// gode_datapath
// Occupancy memory, cell sweep counters, nearest-cell search and root unit.
// ----------------------------------------------------------------------------
module gode_datapath import gode_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  gode_item_t   item,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  gode_cmd_t    cmd,
	output gode_status_t status,
	output logic         done,
	output gode_result_t result
);

	logic [CFG_W-1:0]   wmax_q;
	logic [CFG_W-1:0]   hmax_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [COORD_W-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [COORD_W-1:0] qx_q, qy_q;
	logic               fill_val_q;
	logic               mem [0:MEM_DEPTH-1];
	logic               rdata_s1;
	logic               valid_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic               found_q;
	logic [D2_W-1:0]    best_q;
	logic               done_q;
	gode_result_t       result_q;

	logic signed [EXT_W-1:0] wmax_e, hmax_e, wreg_s, hreg_s;
	logic signed [EXT_W-1:0] x1, y1, x2, y2;
	logic signed [EXT_W-1:0] xl, xh, yl, yh, xl_c, xh_c, yl_c, yh_c, qx_c, qy_c;
	logic [ADDR_W-1:0]       addr;
	logic [COORD_W-1:0]      adx, ady;
	logic [2*COORD_W-1:0]    sqx, sqy;
	logic [D2_W-1:0]         d2;
	logic [ROOT_W-1:0]       root;
	logic                    sq_done;
	logic [SAT_W-1:0]        root_ext;
	logic [DIST_W-1:0]       dist_sat;

	assign wreg_s = signed'(EXT_W'(wmax_q));
	assign hreg_s = signed'(EXT_W'(hmax_q));
	assign wmax_e = (wreg_s > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : wreg_s;
	assign hmax_e = (hreg_s > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : hreg_s;

	assign x1 = EXT_W'(item.corner_one_x);
	assign y1 = EXT_W'(item.corner_one_y);
	assign x2 = EXT_W'(item.corner_two_x);
	assign y2 = EXT_W'(item.corner_two_y);

	assign xl   = (x1 < x2) ? x1 : x2;
	assign xh   = (x1 < x2) ? x2 : x1;
	assign yl   = (y1 < y2) ? y1 : y2;
	assign yh   = (y1 < y2) ? y2 : y1;
	assign xl_c = (xl < 0) ? '0 : xl;
	assign yl_c = (yl < 0) ? '0 : yl;
	assign xh_c = (xh > wmax_e) ? wmax_e : xh;
	assign yh_c = (yh > hmax_e) ? hmax_e : yh;

	assign qx_c = (x1 < 0) ? '0 : ((x1 > wmax_e) ? wmax_e : x1);
	assign qy_c = (y1 < 0) ? '0 : ((y1 > hmax_e) ? hmax_e : y1);

	assign status.is_query   = item.operation == OP_QUERY;
	assign status.fill_empty = (xl_c > xh_c) || (yl_c > yh_c);
	assign status.last       = (x_q == x_hi_q) && (y_q == y_hi_q);
	assign status.sq_done    = sq_done;

	assign addr = {y_q, x_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmax_q <= CFG_RESET;
			hmax_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH_MAX:  wmax_q <= cfg_wdata;
				REG_HEIGHT_MAX: hmax_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			y_q        <= '0;
			x_lo_q     <= '0;
			y_lo_q     <= '0;
			x_hi_q     <= COORD_W'(MAX_DIM);
			y_hi_q     <= COORD_W'(MAX_DIM);
			fill_val_q <= 1'b0;
		end else if (cmd.load) begin
			fill_val_q <= item.fill_value;
			if (item.operation == OP_QUERY) begin
				x_q    <= '0;
				y_q    <= '0;
				x_lo_q <= '0;
				y_lo_q <= '0;
				x_hi_q <= wmax_e[COORD_W-1:0];
				y_hi_q <= hmax_e[COORD_W-1:0];
			end else begin
				x_q    <= xl_c[COORD_W-1:0];
				y_q    <= yl_c[COORD_W-1:0];
				x_lo_q <= xl_c[COORD_W-1:0];
				y_lo_q <= yl_c[COORD_W-1:0];
				x_hi_q <= xh_c[COORD_W-1:0];
				y_hi_q <= yh_c[COORD_W-1:0];
			end
		end else if (cmd.step) begin
			if (x_q == x_hi_q) begin
				x_q <= x_lo_q;
				y_q <= y_q + COORD_W'(1);
			end else begin
				x_q <= x_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qx_q <= qx_c[COORD_W-1:0];
			qy_q <= qy_c[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[addr] <= fill_val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rdata_s1 <= mem[addr];
		end
		x_s1 <= x_q;
		y_s1 <= y_q;
	end

	assign adx = (x_s1 >= qx_q) ? (x_s1 - qx_q) : (qx_q - x_s1);
	assign ady = (y_s1 >= qy_q) ? (y_s1 - qy_q) : (qy_q - y_s1);
	assign sqx = {{COORD_W{1'b0}}, adx} * {{COORD_W{1'b0}}, adx};
	assign sqy = {{COORD_W{1'b0}}, ady} * {{COORD_W{1'b0}}, ady};
	assign d2  = D2_W'(sqx) + D2_W'(sqy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan;
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (valid_s1 && rdata_s1) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && rdata_s1 && (!found_q || d2 < best_q)) begin
			best_q <= d2;
		end
	end

	gode_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (RAD_W'({best_q, {(2*FRAC_W){1'b0}}})),
		.root     (root),
		.done     (sq_done)
	);

	assign root_ext = SAT_W'(root);
	assign dist_sat = (root_ext > SAT_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.distance      <= found_q ? dist_sat : DIST_MAX;
			result_q.cell_occupied <= found_q && (best_q == '0);
			result_q.no_obstacle   <= !found_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.emit))
		else $error("result strobe without an emit command");

	a_empty_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.no_obstacle) |-> (result_q.distance == DIST_MAX
			&& !result_q.cell_occupied))
		else $error("empty grid result not saturated");

endmodule

[rtl/gode_ctrl.sv]
// ----------------------------------------------------------------------------
// gode_ctrl
// Sequencer: reset clear sweep, rectangle fill, query scan and root.
// ----------------------------------------------------------------------------
module gode_ctrl import gode_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  gode_status_t status,
	output gode_cmd_t    cmd,
	output logic         busy
);

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_FILL    = 7'b0000100,
		S_SCAN    = 7'b0001000,
		S_DRAIN   = 7'b0010000,
		S_SQ_INIT = 7'b0100000,
		S_SQ_WAIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.write = 1'b1;
				cmd.step  = 1'b1;
				if (status.last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (status.is_query) begin
						state_d = S_SCAN;
					end else if (!status.fill_empty) begin
						state_d = S_FILL;
					end
				end
			end
			S_FILL: begin
				cmd.write = 1'b1;
				cmd.step  = 1'b1;
				if (status.last) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				cmd.step = 1'b1;
				if (status.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_SQ_INIT;
			end
			S_SQ_INIT: begin
				cmd.sq_start = 1'b1;
				state_d      = S_SQ_WAIT;
			end
			S_SQ_WAIT: begin
				if (status.sq_done) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	a_write_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.write && cmd.scan))
		else $error("memory write and scan read in the same cycle");

	a_emit_needs_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.sq_done)
		else $error("emit before the root is ready");

	a_idle_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.step && !cmd.write)
		else $error("sweep active while idle");

endmodule

[rtl/grid_obstacle_distance_engine_unit.sv]
// ----------------------------------------------------------------------------
// grid_obstacle_distance_engine_unit
// Occupancy grid with brute-force nearest obstacle distance queries.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an item while busy is low; the item transfers at that
//   edge. A fill item writes one grid cell per cycle over the clamped
//   rectangle and gives no result; an empty rectangle ends at once.
//   A query item reads one cell per cycle over the whole grid in use, then
//   runs a square root one bit per cycle. busy drops with the strobe, so the
//   next item can transfer while done is high. The single-port occupancy
//   memory sets this rate: one item at a time.
//   done is high for exactly one cycle with result valid; the receiver
//   cannot stall, so it must take the result in that cycle.
//   cfg_we writes grid_width_max (index 0) or grid_height_max (index 1)
//   at once; write only while busy is low.
//   After reset the block sweeps the memory to clear it, one cell a cycle,
//   with busy high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module grid_obstacle_distance_engine_unit import gode_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  gode_item_t       item,
	output logic             busy,
	output logic             done,
	output gode_result_t     result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	gode_cmd_t    cmd;
	gode_status_t status;

	gode_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	gode_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

endmodule
